// ===== rtl/tkkl_pkg.sv =====
// Shared constants and types for the top-k keep-largest block.
// No dependencies; imported by the interfaces and every module.
package tkkl_pkg;

   localparam int TKKL_CAPACITY    = 16;
   localparam int TKKL_SCORE_WIDTH = 32;

   localparam int MODE_W    = 2;
   localparam int SLOT_W    = 4;
   localparam int COUNT_W   = 5;
   localparam int PAYLOAD_W = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_CAPACITY_ADDR = 2'd0;
   localparam logic [COUNT_W-1:0]    CAPACITY_RESET    = 5'd16;

   typedef struct packed {
      logic first;
      logic step;
      logic decide;
   } min_ctl_type;

endpackage

// ===== rtl/tkkl_if.sv =====
// Request and response channel interfaces for the top-k block.
// Depends on tkkl_pkg.
interface tkkl_req_if import tkkl_pkg::*; #(
   parameter int SCORE_WIDTH = TKKL_SCORE_WIDTH
);
   logic                          valid;
   logic                          ready;
   logic [MODE_W-1:0]             mode;
   logic signed [SCORE_WIDTH-1:0] new_score;
   logic [PAYLOAD_W-1:0]          new_payload;
   logic [SLOT_W-1:0]             read_slot;

   modport source (output valid, mode, new_score, new_payload, read_slot, input ready);
   modport sink   (input valid, mode, new_score, new_payload, read_slot, output ready);
endinterface

interface tkkl_rsp_if import tkkl_pkg::*; #(
   parameter int SCORE_WIDTH = TKKL_SCORE_WIDTH
);
   logic                          valid;
   logic                          ready;
   logic                          kept;
   logic                          evicted;
   logic [SLOT_W-1:0]             slot_index;
   logic signed [SCORE_WIDTH-1:0] slot_score;
   logic [PAYLOAD_W-1:0]          slot_payload;
   logic                          slot_valid;
   logic [COUNT_W-1:0]            held_count;

   modport source (output valid, kept, evicted, slot_index, slot_score, slot_payload,
                   slot_valid, held_count, input ready);
   modport sink   (input valid, kept, evicted, slot_index, slot_score, slot_payload,
                   slot_valid, held_count, output ready);
endinterface

// ===== rtl/top_k_keep_largest.sv =====
// Top-k keep-largest: holds the highest-scored entries of a request stream.
// Depends on tkkl_pkg, tkkl_if, tkkl_store and tkkl_min_unit.
//
// One request is in flight at a time; req is ready only while the sequencer
// is idle. Append, clear and no-op requests go from idle to the response
// state; a read passes through a read state for the registered memory read.
// An insert into a full store scans the first capacity slots, where capacity
// is min(capacity_in_use, CAPACITY): each goes through the single read port
// and the single comparator, one per cycle, then a decide/write-back state
// and the response state follow. A pending response that is not taken holds
// the sequencer. The store needs no clearing after reset.
module top_k_keep_largest import tkkl_pkg::*; #(
   parameter int CAPACITY    = TKKL_CAPACITY,
   parameter int SCORE_WIDTH = TKKL_SCORE_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   tkkl_req_if.sink              req_bus,
   tkkl_rsp_if.source            rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int IDX_W = $clog2(CAPACITY);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [COUNT_W-1:0]     cap_ff, cap_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [COUNT_W-1:0]     tag_ff, tag_in;
   logic [COUNT_W-1:0]     eff_cap;
   logic [SCORE_WIDTH-1:0] new_score_ff, new_score_in;
   logic [PAYLOAD_W-1:0]   new_payload_ff, new_payload_in;
   logic                   read_ok_ff, read_ok_in;

   logic                   res_kept_ff, res_kept_in;
   logic                   res_evicted_ff, res_evicted_in;
   logic [SLOT_W-1:0]      res_index_ff, res_index_in;
   logic [SCORE_WIDTH-1:0] res_score_ff, res_score_in;
   logic [PAYLOAD_W-1:0]   res_payload_ff, res_payload_in;
   logic                   res_valid_ff, res_valid_in;
   logic [COUNT_W-1:0]     res_held_ff, res_held_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kept_ff, rsp_evicted_ff, rsp_slot_valid_ff;
   logic [SLOT_W-1:0]      rsp_index_ff;
   logic [SCORE_WIDTH-1:0] rsp_score_ff;
   logic [PAYLOAD_W-1:0]   rsp_payload_ff;
   logic [COUNT_W-1:0]     rsp_held_ff;
   logic                   rsp_load;

   logic                   req_fire;
   logic                   csr_write;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [SCORE_WIDTH-1:0] wr_score;
   logic [PAYLOAD_W-1:0]   wr_payload;
   logic [IDX_W-1:0]       rd_addr;
   logic [SCORE_WIDTH-1:0] rd_score;
   logic [PAYLOAD_W-1:0]   rd_payload;

   min_ctl_type            min_ctl;
   logic [SCORE_WIDTH-1:0] min_score;
   logic [PAYLOAD_W-1:0]   min_payload;
   logic [COUNT_W-1:0]     min_idx;
   logic                   min_less;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr == CSR_CAPACITY_ADDR);
   assign cap_in    = csr_write ? pwdata[COUNT_W-1:0] : cap_ff;
   assign prdata    = {{(CSR_DATA_W-COUNT_W){1'b0}}, cap_ff};

   assign eff_cap = (32'(cap_ff) > CAPACITY) ? COUNT_W'(CAPACITY) : cap_ff;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign rd_addr = (state_ff == S_SCAN) ? IDX_W'(tag_ff + COUNT_W'(1)) :
                    (req_bus.mode == MODE_READ) ? IDX_W'(req_bus.read_slot) : '0;

   tkkl_store #(
      .CAPACITY    (CAPACITY),
      .SCORE_WIDTH (SCORE_WIDTH)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_score   (wr_score),
      .wr_payload (wr_payload),
      .rd_addr    (rd_addr),
      .rd_score   (rd_score),
      .rd_payload (rd_payload)
   );

   tkkl_min_unit #(
      .SCORE_WIDTH (SCORE_WIDTH)
   ) u_min (
      .clock        (clock),
      .ctl          (min_ctl),
      .cand_score   (rd_score),
      .cand_payload (rd_payload),
      .cand_idx     (tag_ff),
      .new_score    (new_score_ff),
      .min_score    (min_score),
      .min_payload  (min_payload),
      .min_idx      (min_idx),
      .less         (min_less)
   );

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      tag_in         = tag_ff;
      new_score_in   = new_score_ff;
      new_payload_in = new_payload_ff;
      read_ok_in     = read_ok_ff;
      res_kept_in    = res_kept_ff;
      res_evicted_in = res_evicted_ff;
      res_index_in   = res_index_ff;
      res_score_in   = res_score_ff;
      res_payload_in = res_payload_ff;
      res_valid_in   = res_valid_ff;
      res_held_in    = res_held_ff;
      wr_en          = 1'b0;
      wr_addr        = IDX_W'(count_ff);
      wr_score       = req_bus.new_score;
      wr_payload     = req_bus.new_payload;
      min_ctl        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               new_score_in   = req_bus.new_score;
               new_payload_in = req_bus.new_payload;
               res_kept_in    = 1'b0;
               res_evicted_in = 1'b0;
               res_index_in   = '0;
               res_score_in   = '0;
               res_payload_in = '0;
               res_valid_in   = 1'b0;
               res_held_in    = count_ff;
               state_in       = S_DONE;
               case (req_bus.mode)
                  MODE_INSERT: begin
                     if (eff_cap == '0) begin
                        state_in = S_DONE;
                     end else if (count_ff < eff_cap) begin
                        wr_en        = 1'b1;
                        res_kept_in  = 1'b1;
                        res_index_in = SLOT_W'(count_ff);
                        count_in     = count_ff + COUNT_W'(1);
                        res_held_in  = count_ff + COUNT_W'(1);
                     end else begin
                        tag_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  MODE_CLEAR: begin
                     count_in    = '0;
                     res_held_in = '0;
                  end
                  MODE_READ: begin
                     res_index_in = req_bus.read_slot;
                     read_ok_in   = (32'(req_bus.read_slot) < CAPACITY) &&
                                    (COUNT_W'(req_bus.read_slot) < count_ff);
                     state_in     = S_READ;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_READ: begin
            res_valid_in   = read_ok_ff;
            res_score_in   = read_ok_ff ? rd_score : '0;
            res_payload_in = read_ok_ff ? rd_payload : '0;
            state_in       = S_DONE;
         end
         S_SCAN: begin
            min_ctl.step  = 1'b1;
            min_ctl.first = (tag_ff == '0);
            if (tag_ff == eff_cap - COUNT_W'(1)) begin
               state_in = S_DECIDE;
            end else begin
               tag_in = tag_ff + COUNT_W'(1);
            end
         end
         S_DECIDE: begin
            min_ctl.decide = 1'b1;
            if (min_less) begin
               wr_en          = 1'b1;
               wr_addr        = IDX_W'(min_idx);
               wr_score       = new_score_ff;
               wr_payload     = new_payload_ff;
               res_kept_in    = 1'b1;
               res_evicted_in = 1'b1;
               res_index_in   = SLOT_W'(min_idx);
               res_score_in   = min_score;
               res_payload_in = min_payload;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAPACITY_RESET;
         count_ff     <= '0;
         tag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         tag_ff       <= tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      new_score_ff   <= new_score_in;
      new_payload_ff <= new_payload_in;
      read_ok_ff     <= read_ok_in;
      res_kept_ff    <= res_kept_in;
      res_evicted_ff <= res_evicted_in;
      res_index_ff   <= res_index_in;
      res_score_ff   <= res_score_in;
      res_payload_ff <= res_payload_in;
      res_valid_ff   <= res_valid_in;
      res_held_ff    <= res_held_in;
      if (rsp_load) begin
         rsp_kept_ff       <= res_kept_ff;
         rsp_evicted_ff    <= res_evicted_ff;
         rsp_index_ff      <= res_index_ff;
         rsp_score_ff      <= res_score_ff;
         rsp_payload_ff    <= res_payload_ff;
         rsp_slot_valid_ff <= res_valid_ff;
         rsp_held_ff       <= res_held_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.kept         = rsp_kept_ff;
   assign rsp_bus.evicted      = rsp_evicted_ff;
   assign rsp_bus.slot_index   = rsp_index_ff;
   assign rsp_bus.slot_score   = rsp_score_ff;
   assign rsp_bus.slot_payload = rsp_payload_ff;
   assign rsp_bus.slot_valid   = rsp_slot_valid_ff;
   assign rsp_bus.held_count   = rsp_held_ff;

endmodule

// ===== rtl/tkkl_store.sv =====
// Score and payload storage: one write port, one registered read port.
// Depends on tkkl_pkg.
module tkkl_store import tkkl_pkg::*; #(
   parameter int CAPACITY    = TKKL_CAPACITY,
   parameter int SCORE_WIDTH = TKKL_SCORE_WIDTH,
   localparam int IDX_W      = $clog2(CAPACITY)
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [IDX_W-1:0]       wr_addr,
   input  logic [SCORE_WIDTH-1:0] wr_score,
   input  logic [PAYLOAD_W-1:0]   wr_payload,
   input  logic [IDX_W-1:0]       rd_addr,
   output logic [SCORE_WIDTH-1:0] rd_score,
   output logic [PAYLOAD_W-1:0]   rd_payload
);

   logic [SCORE_WIDTH-1:0] score_mem   [CAPACITY];
   logic [PAYLOAD_W-1:0]   payload_mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         score_mem[wr_addr]   <= wr_score;
         payload_mem[wr_addr] <= wr_payload;
      end
      rd_score   <= score_mem[rd_addr];
      rd_payload <= payload_mem[rd_addr];
   end

endmodule

// ===== rtl/tkkl_min_unit.sv =====
// Shared signed comparator with running-minimum registers.
// Depends on tkkl_pkg (min_ctl_type).
module tkkl_min_unit import tkkl_pkg::*; #(
   parameter int SCORE_WIDTH = TKKL_SCORE_WIDTH
) (
   input  logic                   clock,
   input  min_ctl_type            ctl,
   input  logic [SCORE_WIDTH-1:0] cand_score,
   input  logic [PAYLOAD_W-1:0]   cand_payload,
   input  logic [COUNT_W-1:0]     cand_idx,
   input  logic [SCORE_WIDTH-1:0] new_score,
   output logic [SCORE_WIDTH-1:0] min_score,
   output logic [PAYLOAD_W-1:0]   min_payload,
   output logic [COUNT_W-1:0]     min_idx,
   output logic                   less
);

   logic [SCORE_WIDTH-1:0] min_score_ff, min_score_in;
   logic [PAYLOAD_W-1:0]   min_payload_ff, min_payload_in;
   logic [COUNT_W-1:0]     min_idx_ff, min_idx_in;
   logic [SCORE_WIDTH-1:0] op_a, op_b;

   // scan: cand < min; decide: min < new
   assign op_a = ctl.decide ? min_score_ff : cand_score;
   assign op_b = ctl.decide ? new_score : min_score_ff;
   assign less = $signed(op_a) < $signed(op_b);

   always_comb begin
      min_score_in   = min_score_ff;
      min_payload_in = min_payload_ff;
      min_idx_in     = min_idx_ff;
      if (ctl.step && (ctl.first || less)) begin
         min_score_in   = cand_score;
         min_payload_in = cand_payload;
         min_idx_in     = cand_idx;
      end
   end

   always_ff @(posedge clock) begin
      min_score_ff   <= min_score_in;
      min_payload_ff <= min_payload_in;
      min_idx_ff     <= min_idx_in;
   end

   assign min_score   = min_score_ff;
   assign min_payload = min_payload_ff;
   assign min_idx     = min_idx_ff;

endmodule

// ===== verif/tkkl_checker.sv =====
// Checker for top_k_keep_largest: watches the request, response and APB ports,
// predicts every response and compares it field by field.
// Depends on tkkl_pkg and the tkkl_req_if / tkkl_rsp_if interfaces.
module tkkl_checker import tkkl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tkkl_req_if                   req_mon,
   tkkl_rsp_if                   rsp_mon,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int                    fail_count,
   output int                    pending,
   output int                    replace_count,
   output int                    drop_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                        kept;
      logic                        evicted;
      logic [SLOT_W-1:0]           slot_index;
      logic [TKKL_SCORE_WIDTH-1:0] slot_score;
      logic [PAYLOAD_W-1:0]        slot_payload;
      logic                        slot_valid;
      logic [COUNT_W-1:0]          held_count;
   } topk_result_type;

   logic [TKKL_SCORE_WIDTH-1:0] score_mem [TKKL_CAPACITY];
   logic [PAYLOAD_W-1:0]        payload_mem [TKKL_CAPACITY];
   int unsigned                 held;
   logic [COUNT_W-1:0]          capacity_reg;
   topk_result_type             result_q [$];

   function automatic int field_error(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Updates the held entries and returns the response the request must produce.
   function automatic topk_result_type apply_request(input logic [MODE_W-1:0] md,
                                                     input logic [31:0] sc,
                                                     input logic [31:0] pl,
                                                     input logic [SLOT_W-1:0] sl);
      topk_result_type r;
      int unsigned     cap;
      int unsigned     low_idx;
      int unsigned     i;
      r = '0;
      cap = (capacity_reg > TKKL_CAPACITY) ? TKKL_CAPACITY : capacity_reg;
      case (md)
         MODE_INSERT: begin
            if (cap != 0 && held < cap) begin
               score_mem[held] = sc;
               payload_mem[held] = pl;
               r.kept = 1'b1;
               r.slot_index = held[SLOT_W-1:0];
               held = held + 1;
            end else if (cap != 0) begin
               low_idx = 0;
               for (i = 1; i < cap; i++) begin
                  if ($signed(score_mem[i]) < $signed(score_mem[low_idx])) begin
                     low_idx = i;
                  end
               end
               if ($signed(sc) > $signed(score_mem[low_idx])) begin
                  r.kept = 1'b1;
                  r.evicted = 1'b1;
                  r.slot_index = low_idx[SLOT_W-1:0];
                  r.slot_score = score_mem[low_idx];
                  r.slot_payload = payload_mem[low_idx];
                  score_mem[low_idx] = sc;
                  payload_mem[low_idx] = pl;
               end
            end
         end
         MODE_CLEAR: begin
            held = 0;
         end
         MODE_READ: begin
            r.slot_index = sl;
            if (sl < held) begin
               r.slot_valid = 1'b1;
               r.slot_score = score_mem[sl];
               r.slot_payload = payload_mem[sl];
            end
         end
         default: ;
      endcase
      r.held_count = held[COUNT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : monitor_edge
      topk_result_type seen;
      topk_result_type want;
      if (reset) begin
         result_q.delete();
         held = 0;
         capacity_reg = CAPACITY_RESET;
         fail_count = 0;
         replace_count = 0;
         drop_count = 0;
         pending <= 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == CSR_CAPACITY_ADDR) begin
            capacity_reg = pwdata[COUNT_W-1:0];
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.kept = rsp_mon.kept;
            seen.evicted = rsp_mon.evicted;
            seen.slot_index = rsp_mon.slot_index;
            seen.slot_score = rsp_mon.slot_score;
            seen.slot_payload = rsp_mon.slot_payload;
            seen.slot_valid = rsp_mon.slot_valid;
            seen.held_count = rsp_mon.held_count;
            if (result_q.size() == 0) begin
               $display("%0t: response with no request outstanding, got %p", $time, seen);
               fail_count++;
            end else begin
               want = result_q.pop_front();
               fail_count += field_error("kept", want.kept, seen.kept)
                           + field_error("evicted", want.evicted, seen.evicted)
                           + field_error("slot_index", want.slot_index, seen.slot_index)
                           + field_error("slot_score", want.slot_score, seen.slot_score)
                           + field_error("slot_payload", want.slot_payload,
                                         seen.slot_payload)
                           + field_error("slot_valid", want.slot_valid, seen.slot_valid)
                           + field_error("held_count", want.held_count, seen.held_count);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            want = apply_request(req_mon.mode, req_mon.new_score, req_mon.new_payload,
                                 req_mon.read_slot);
            if (req_mon.mode == MODE_INSERT && !want.kept) begin
               drop_count++;
            end
            if (want.evicted) begin
               replace_count++;
            end
            result_q.push_back(want);
         end
         pending <= result_q.size();
      end
   end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for top_k_keep_largest: clock, reset, request and APB stimulus,
// response back-pressure and the final verdict.
// Depends on tkkl_pkg, the tkkl interfaces, the block itself and tkkl_checker.
module tb_top;
   import tkkl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
   localparam int ITEM_TARGET = 700;
   localparam int CYCLE_LIMIT = 600000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int pending;
   int replace_count;
   int drop_count;
   int cycle_count = 0;
   int sent_by_mode [4] = '{0, 0, 0, 0};
   int settings_used = 0;
   int cap_plan [6] = '{16, 1, 31, 0, 5, 2};

   int ready_style = 0;
   int style_timer = 0;
   int stall_hold = 0;

   tkkl_req_if req_bus ();
   tkkl_rsp_if rsp_bus ();

   top_k_keep_largest uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   tkkl_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .replace_count (replace_count),
      .drop_count    (drop_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d responses outstanding",
                  $time, cycle_count, pending);
         $display("simulation failed");
         $finish;
      end
   end

   // Response back-pressure: always ready, random, or long on/off stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (style_timer == 0) begin
            ready_style <= $urandom_range(0, 2);
            style_timer <= $urandom_range(50, 300);
         end else begin
            style_timer <= style_timer - 1;
         end
         case (ready_style)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            default: begin
               if (stall_hold != 0) begin
                  stall_hold <= stall_hold - 1;
               end else begin
                  rsp_bus.ready <= !rsp_bus.ready;
                  stall_hold <= $urandom_range(0, 15);
               end
            end
         endcase
      end
   end

   task automatic offer(input logic [MODE_W-1:0] md, input logic [31:0] sc,
                        input logic [31:0] pl, input logic [SLOT_W-1:0] sl);
      req_bus.valid <= 1'b1;
      req_bus.mode <= md;
      req_bus.new_score <= sc;
      req_bus.new_payload <= pl;
      req_bus.read_slot <= sl;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent_by_mode[md]++;
   endtask

   task automatic pause(input int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drains all outstanding requests, then writes the capacity register over APB.
   task automatic write_capacity(input logic [CSR_DATA_W-1:0] value);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_CAPACITY_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [31:0] pick_score();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2, 3: return $urandom_range(0, 16) - 8;
         default: return $urandom();
      endcase
   endfunction

   initial begin : stimulus
      int                counted;
      int                phase;
      int                quota;
      int                done_in_phase;
      int                burst;
      int                pick;
      logic [MODE_W-1:0] md;
      logic [4:0]        cap;
      counted = 0;
      phase = 0;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_INSERT;
      req_bus.new_score = '0;
      req_bus.new_payload = '0;
      req_bus.read_slot = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // extreme scores and payloads, reads in and out of the held range
      offer(MODE_INSERT, 32'h8000_0000, 32'h0000_0000, 4'd0);
      offer(MODE_INSERT, 32'h7fff_ffff, 32'hffff_ffff, 4'd15);
      offer(MODE_READ, 32'h0, 32'h0, 4'd0);
      offer(MODE_READ, 32'h0, 32'h0, 4'd1);
      offer(MODE_READ, 32'hffff_ffff, 32'hffff_ffff, 4'd15);
      offer(MODE_NOP, 32'h1234_5678, 32'h9abc_def0, 4'd3);
      offer(MODE_CLEAR, 32'h0, 32'h0, 4'd0);
      offer(MODE_READ, 32'h0, 32'h0, 4'd0);
      // zero capacity drops, oversized capacity saturates
      write_capacity(32'd0);
      offer(MODE_INSERT, 32'd7, 32'h0000_00aa, 4'd0);
      write_capacity(32'd31);
      offer(MODE_INSERT, 32'd5, 32'h0000_00a0, 4'd0);
      // full store: equal score dropped, first lowest index replaced
      write_capacity(32'd2);
      offer(MODE_INSERT, 32'd5, 32'h0000_00a1, 4'd0);
      offer(MODE_INSERT, 32'd5, 32'h0000_00a2, 4'd0);
      offer(MODE_INSERT, 32'd6, 32'h0000_00a3, 4'd0);
      offer(MODE_INSERT, 32'hffff_ffff, 32'h0000_00a4, 4'd0);
      // capacity lowered below the held count
      write_capacity(32'd4);
      offer(MODE_INSERT, 32'd1, 32'h0000_00b0, 4'd0);
      offer(MODE_INSERT, 32'd2, 32'h0000_00b1, 4'd0);
      write_capacity(32'd1);
      offer(MODE_INSERT, 32'd100, 32'h0000_00c0, 4'd0);
      offer(MODE_READ, 32'h0, 32'h0, 4'd3);
      offer(MODE_INSERT, 32'h8000_0000, 32'h0000_00c1, 4'd0);
      pause(1);
      counted = sent_by_mode[MODE_INSERT] + sent_by_mode[MODE_READ]
              + sent_by_mode[MODE_CLEAR];

      while (counted < ITEM_TARGET) begin
         cap = (phase < 6) ? 5'(cap_plan[phase]) : 5'($urandom_range(1, 20));
         write_capacity({27'd0, cap});
         quota = (cap == 0) ? 20 : $urandom_range(60, 120);
         done_in_phase = 0;
         while (done_in_phase < quota && counted < ITEM_TARGET) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
            repeat (burst) begin
               pick = $urandom_range(0, 99);
               if (pick < 78) md = MODE_INSERT;
               else if (pick < 93) md = MODE_READ;
               else if (pick < 97) md = MODE_CLEAR;
               else md = MODE_NOP;
               offer(md, pick_score(), $urandom(), 4'($urandom_range(0, 15)));
               if (md != MODE_NOP) begin
                  done_in_phase++;
                  counted++;
               end
            end
            pause($urandom_range(1, 10));
         end
         phase++;
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d inserts, %0d reads, %0d clears, %0d no-ops over %0d capacity writes.",
               sent_by_mode[MODE_INSERT], sent_by_mode[MODE_READ],
               sent_by_mode[MODE_CLEAR], sent_by_mode[MODE_NOP], settings_used);
      $display("Expected %0d replacements and %0d dropped inserts; %0d field mismatches.",
               replace_count, drop_count, fail_count);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
